>>> src/wapm_pkg.sv
// ----------------------------------------------------------------------------
// wapm_pkg: shared types and codes for the power mode controller
// Event opcodes, power mode codes, register indexes and bundled structs.
// ----------------------------------------------------------------------------
package wapm_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned OpW   = 3;
  localparam int unsigned ModeW = 3;
  localparam int unsigned CfgIdxW = 2;

  // event opcodes
  localparam logic [OpW-1:0] OP_UPDATE = 3'd0;
  localparam logic [OpW-1:0] OP_START  = 3'd1;
  localparam logic [OpW-1:0] OP_BUTTON = 3'd2;
  localparam logic [OpW-1:0] OP_TIMER  = 3'd3;
  localparam logic [OpW-1:0] OP_OTHER  = 3'd4;

  // power modes
  localparam logic [ModeW-1:0] M_ACTIVE = 3'd0;
  localparam logic [ModeW-1:0] M_WCHECK = 3'd1;
  localparam logic [ModeW-1:0] M_TRANS  = 3'd2;
  localparam logic [ModeW-1:0] M_LIGHT  = 3'd3;
  localparam logic [ModeW-1:0] M_DEEP   = 3'd4;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_GRACE   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_REMOVAL = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_IDLE    = 2'd2;

  localparam logic [TimeW-1:0] GRACE_RST   = 32'd10000;
  localparam logic [TimeW-1:0] REMOVAL_RST = 32'd60000;
  localparam logic [TimeW-1:0] IDLE_RST    = 32'd300000;

  typedef struct packed {
    logic [OpW-1:0]   opcode;
    logic [TimeW-1:0] now_ms;
    logic             radio_connected;
    logic             worn;
    logic             motion_detected;
  } item_t;

  typedef struct packed {
    logic [ModeW-1:0] power_mode;
    logic             dim_sensors;
    logic             restore_sensors;
    logic             radio_stop;
    logic             radio_start;
    logic             wear_check_request;
    logic             light_sleep_request;
    logic             deep_sleep_request;
  } res_t;

  typedef struct packed {
    logic [TimeW-1:0] grace_period_ms;
    logic [TimeW-1:0] removal_timeout_ms;
    logic [TimeW-1:0] idle_timeout_ms;
  } cfg_t;

endpackage

>>> src/wapm_cfg_regs.sv
// ----------------------------------------------------------------------------
// wapm_cfg_regs: timeout register file
// Holds grace, removal and idle timeouts; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module wapm_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [wapm_pkg::CfgIdxW-1:0]  wr_index,
  input  logic [wapm_pkg::TimeW-1:0]    wr_data,
  output wapm_pkg::cfg_t                cfg
);
  import wapm_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grace_period_ms    <= GRACE_RST;
      cfg_r.removal_timeout_ms <= REMOVAL_RST;
      cfg_r.idle_timeout_ms    <= IDLE_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_GRACE:   cfg_r.grace_period_ms    <= wr_data;
        REG_REMOVAL: cfg_r.removal_timeout_ms <= wr_data;
        REG_IDLE:    cfg_r.idle_timeout_ms    <= wr_data;
        default:     ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> src/wapm_mode_core.sv
// ----------------------------------------------------------------------------
// wapm_mode_core: power mode state and event transition logic
// Evaluates one registered event against mode and stamps; commits on advance.
// ----------------------------------------------------------------------------
module wapm_mode_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  wapm_pkg::item_t  item,
  input  wapm_pkg::cfg_t   cfg,
  output wapm_pkg::res_t   res
);
  import wapm_pkg::*;

  logic [ModeW-1:0] mode_r, mode_nxt;
  logic [TimeW-1:0] start_r, start_nxt;
  logic [TimeW-1:0] removal_r, removal_nxt;
  logic [TimeW-1:0] activity_r, activity_nxt;

  logic [TimeW-1:0] since_start, since_removal, since_activity;
  logic             in_grace, idle, removal_due;

  assign since_start    = item.now_ms - start_r;
  assign since_removal  = item.now_ms - removal_r;
  assign since_activity = item.now_ms - activity_r;
  assign in_grace    = since_start < cfg.grace_period_ms;
  assign removal_due = since_removal >= cfg.removal_timeout_ms;
  assign idle        = !item.radio_connected && (since_activity > cfg.idle_timeout_ms);

  always_comb begin
    mode_nxt     = mode_r;
    start_nxt    = start_r;
    removal_nxt  = removal_r;
    activity_nxt = activity_r;
    res          = '0;
    unique case (item.opcode)
      OP_UPDATE: begin
        if (!in_grace) begin
          unique case (mode_r)
            M_ACTIVE: begin
              if (!item.worn) begin
                removal_nxt = item.now_ms;
                mode_nxt    = M_WCHECK;
              end
            end
            M_WCHECK: begin
              if (item.worn) mode_nxt = M_ACTIVE;
              else if (removal_due) mode_nxt = M_TRANS;
            end
            M_TRANS: begin
              if (item.worn || item.motion_detected) begin
                mode_nxt = M_ACTIVE;
              end else begin
                mode_nxt                = M_LIGHT;
                res.dim_sensors         = 1'b1;
                res.radio_stop          = 1'b1;
                res.light_sleep_request = 1'b1;
              end
            end
            M_LIGHT: mode_nxt = M_ACTIVE;
            default: begin
              // deep sleep holds; request repeats while idle
              if (idle) res.deep_sleep_request = 1'b1;
            end
          endcase
          if (mode_nxt == M_ACTIVE && idle) begin
            mode_nxt               = M_DEEP;
            res.deep_sleep_request = 1'b1;
          end
        end
      end
      OP_START: begin
        start_nxt    = item.now_ms;
        activity_nxt = item.now_ms;
        mode_nxt     = M_ACTIVE;
      end
      OP_BUTTON: begin
        res.restore_sensors = 1'b1;
        res.radio_start     = 1'b1;
        mode_nxt            = M_ACTIVE;
        activity_nxt        = item.now_ms;
      end
      OP_TIMER: begin
        if (mode_r == M_LIGHT) begin
          res.wear_check_request = 1'b1;
          if (item.motion_detected) begin
            res.restore_sensors = 1'b1;
            res.radio_start     = 1'b1;
            mode_nxt            = M_ACTIVE;
            activity_nxt        = item.now_ms;
          end else begin
            res.light_sleep_request = 1'b1;
          end
        end
      end
      OP_OTHER: begin
        if (mode_r == M_LIGHT) res.light_sleep_request = 1'b1;
      end
      default: ;
    endcase
    res.power_mode = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= M_ACTIVE;
      start_r    <= '0;
      removal_r  <= '0;
      activity_r <= '0;
    end else if (adv) begin
      mode_r     <= mode_nxt;
      start_r    <= start_nxt;
      removal_r  <= removal_nxt;
      activity_r <= activity_nxt;
    end
  end

  a_dim_goes_light: assert property (@(posedge clk) disable iff (!rst_n)
    res.dim_sensors |-> (res.power_mode == M_LIGHT) && res.radio_stop
                        && res.light_sleep_request)
    else $error("dim pulse without light sleep entry");

  a_restore_active: assert property (@(posedge clk) disable iff (!rst_n)
    res.restore_sensors |-> (res.power_mode == M_ACTIVE) && res.radio_start)
    else $error("restore pulse outside wake to active");

  a_deep_mode: assert property (@(posedge clk) disable iff (!rst_n)
    res.deep_sleep_request |-> (res.power_mode == M_DEEP))
    else $error("deep sleep request outside deep sleep");

  a_start_active: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && item.opcode == OP_START) |=> (mode_r == M_ACTIVE)
                                         && (start_r == activity_r))
    else $error("start event did not reset mode and stamps");

endmodule

>>> src/wear_aware_power_mode_controller_unit.sv
// ----------------------------------------------------------------------------
// wear_aware_power_mode_controller_unit: wear-aware power mode controller
// Path: an accepted event is held in the input register, then in the result
//   register that drives out_*. Throughput: one event per cycle unless out_stall
//   holds the result register; the mode and stamp registers update in the
//   same cycle the result register loads, so back-to-back events chain.
// Reset (rst_n low, synchronous): mode active, stamps zero, timeouts at
//   their defaults, both pipeline registers empty.
// ----------------------------------------------------------------------------
module wear_aware_power_mode_controller_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // event channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [wapm_pkg::OpW-1:0]      in_opcode,
  input  logic [wapm_pkg::TimeW-1:0]    in_now_ms,
  input  logic                          in_radio_connected,
  input  logic                          in_worn,
  input  logic                          in_motion_detected,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [wapm_pkg::ModeW-1:0]    out_power_mode,
  output logic                          out_dim_sensors,
  output logic                          out_restore_sensors,
  output logic                          out_radio_stop,
  output logic                          out_radio_start,
  output logic                          out_wear_check_request,
  output logic                          out_light_sleep_request,
  output logic                          out_deep_sleep_request,
  // register write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wapm_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [wapm_pkg::TimeW-1:0]    cfg_data
);
  import wapm_pkg::*;

  item_t item_r;
  logic  in_valid_r;
  res_t  res_r;
  logic  out_valid_r;

  res_t  res;
  cfg_t  cfg;
  logic  adv;
  logic  in_take;

  // Registers are always writable; writes must land only while idle, which the block itself does not enforce.
  assign cfg_ready = 1'b1;

  wapm_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The held event moves into the result register whenever that register is
  // empty or being drained this cycle. The state commit rides the same strobe.
  assign adv      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  wapm_mode_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.opcode          <= in_opcode;
      item_r.now_ms          <= in_now_ms;
      item_r.radio_connected <= in_radio_connected;
      item_r.worn            <= in_worn;
      item_r.motion_detected <= in_motion_detected;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_power_mode          = res_r.power_mode;
  assign out_dim_sensors         = res_r.dim_sensors;
  assign out_restore_sensors     = res_r.restore_sensors;
  assign out_radio_stop          = res_r.radio_stop;
  assign out_radio_start         = res_r.radio_start;
  assign out_wear_check_request  = res_r.wear_check_request;
  assign out_light_sleep_request = res_r.light_sleep_request;
  assign out_deep_sleep_request  = res_r.deep_sleep_request;

endmodule

>>> tb/wapm_mode_checker.sv
// ----------------------------------------------------------------------------
// wapm_mode_checker: result checker for the power mode controller
// Watches the event, result and register write channels, keeps its own copy
// of the mode, stamps and timeouts, and compares every result transaction
// with the oldest predicted one.
// ----------------------------------------------------------------------------
module wapm_mode_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [wapm_pkg::OpW-1:0]      in_opcode,
  input  logic [wapm_pkg::TimeW-1:0]    in_now_ms,
  input  logic                          in_radio_connected,
  input  logic                          in_worn,
  input  logic                          in_motion_detected,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [wapm_pkg::ModeW-1:0]    out_power_mode,
  input  logic                          out_dim_sensors,
  input  logic                          out_restore_sensors,
  input  logic                          out_radio_stop,
  input  logic                          out_radio_start,
  input  logic                          out_wear_check_request,
  input  logic                          out_light_sleep_request,
  input  logic                          out_deep_sleep_request,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [wapm_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [wapm_pkg::TimeW-1:0]    cfg_data,
  output int unsigned                   mismatch_count,
  output int unsigned                   pending_count,
  output int unsigned                   result_count,
  output int unsigned                   light_entries,
  output int unsigned                   deep_requests
);
  import wapm_pkg::*;

  // predicted block state
  logic [TimeW-1:0] grace_ms, removal_ms, idle_ms;
  logic [ModeW-1:0] mode_now;
  logic [TimeW-1:0] start_ms, removed_ms, active_ms;

  res_t pending_results[$];

  function automatic string fmt_res(input res_t r);
    return $sformatf("mode=%0d dim=%b restore=%b stop=%b start=%b wear=%b light=%b deep=%b",
                     r.power_mode, r.dim_sensors, r.restore_sensors, r.radio_stop,
                     r.radio_start, r.wear_check_request, r.light_sleep_request,
                     r.deep_sleep_request);
  endfunction

  task automatic log_failure(input string msg);
    if (mismatch_count < 10) $display("[%0t] MISMATCH %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic wake_from_sleep(input logic [TimeW-1:0] now, inout res_t r);
    r.restore_sensors = 1'b1;
    r.radio_start = 1'b1;
    mode_now = M_ACTIVE;
    active_ms = now;
  endtask

  task automatic predict_power_event(input item_t ev, output res_t r);
    logic [TimeW-1:0] since_start, since_active, since_removed;
    logic idle;
    r = '0;
    since_start = ev.now_ms - start_ms;
    since_active = ev.now_ms - active_ms;
    since_removed = ev.now_ms - removed_ms;
    case (ev.opcode)
      OP_UPDATE: begin
        if (since_start >= grace_ms) begin
          idle = !ev.radio_connected && (since_active > idle_ms);
          case (mode_now)
            M_ACTIVE: begin
              if (!ev.worn) begin
                removed_ms = ev.now_ms;
                mode_now = M_WCHECK;
              end
            end
            M_WCHECK: begin
              if (ev.worn) mode_now = M_ACTIVE;
              else if (since_removed >= removal_ms) mode_now = M_TRANS;
            end
            M_TRANS: begin
              if (ev.worn || ev.motion_detected) begin
                mode_now = M_ACTIVE;
              end else begin
                mode_now = M_LIGHT;
                r.dim_sensors = 1'b1;
                r.radio_stop = 1'b1;
                r.light_sleep_request = 1'b1;
              end
            end
            M_LIGHT: mode_now = M_ACTIVE;
            default: begin
              // deep sleep holds; request repeats while idle
              if (idle) r.deep_sleep_request = 1'b1;
            end
          endcase
          if (mode_now == M_ACTIVE && idle) begin
            mode_now = M_DEEP;
            r.deep_sleep_request = 1'b1;
          end
        end
      end
      OP_START: begin
        start_ms = ev.now_ms;
        active_ms = ev.now_ms;
        mode_now = M_ACTIVE;
      end
      OP_BUTTON: wake_from_sleep(ev.now_ms, r);
      OP_TIMER: begin
        if (mode_now == M_LIGHT) begin
          r.wear_check_request = 1'b1;
          if (ev.motion_detected) wake_from_sleep(ev.now_ms, r);
          else r.light_sleep_request = 1'b1;
        end
      end
      OP_OTHER: begin
        if (mode_now == M_LIGHT) r.light_sleep_request = 1'b1;
      end
      default: ;
    endcase
    r.power_mode = mode_now;
  endtask

  always @(posedge clk) begin : monitor
    res_t got;
    res_t want;
    item_t ev;
    if (!rst_n) begin
      grace_ms = GRACE_RST;
      removal_ms = REMOVAL_RST;
      idle_ms = IDLE_RST;
      mode_now = M_ACTIVE;
      start_ms = '0;
      removed_ms = '0;
      active_ms = '0;
      pending_results.delete();
      mismatch_count = 0;
      result_count = 0;
      light_entries = 0;
      deep_requests = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GRACE:   grace_ms = cfg_data;
          REG_REMOVAL: removal_ms = cfg_data;
          REG_IDLE:    idle_ms = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got.power_mode = out_power_mode;
        got.dim_sensors = out_dim_sensors;
        got.restore_sensors = out_restore_sensors;
        got.radio_stop = out_radio_stop;
        got.radio_start = out_radio_start;
        got.wear_check_request = out_wear_check_request;
        got.light_sleep_request = out_light_sleep_request;
        got.deep_sleep_request = out_deep_sleep_request;
        if (pending_results.size() == 0) begin
          log_failure($sformatf("result %0d with nothing expected: got %s",
                                result_count, fmt_res(got)));
        end else begin
          want = pending_results.pop_front();
          if (got !== want)
            log_failure($sformatf("result %0d: expected %s, got %s",
                                  result_count, fmt_res(want), fmt_res(got)));
        end
        result_count++;
      end
      if (in_valid && !in_stall) begin
        ev.opcode = in_opcode;
        ev.now_ms = in_now_ms;
        ev.radio_connected = in_radio_connected;
        ev.worn = in_worn;
        ev.motion_detected = in_motion_detected;
        predict_power_event(ev, want);
        if (want.dim_sensors) light_entries++;
        if (want.deep_sleep_request) deep_requests++;
        pending_results.push_back(want);
      end
    end
    pending_count = pending_results.size();
  end

endmodule

>>> tb/wear_aware_power_mode_controller_unit_test.sv
// ----------------------------------------------------------------------------
// wear_aware_power_mode_controller_unit_test: testbench top
// Drives timestamped power events and register writes into the controller,
// stalls the result channel on a pattern of its own, and leaves prediction
// and comparison to the checker beside the block. Gives the verdict.
// ----------------------------------------------------------------------------
module wear_aware_power_mode_controller_unit_test;
  import wapm_pkg::*;

  // index with no register behind it; writes to it must be dropped
  localparam logic [CfgIdxW-1:0] REG_SPARE = 2'd3;
  // long receiver hold-off, long enough to back the pipeline up
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned DRAIN_GUARD = 20000;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  logic               in_valid;
  logic               in_stall;
  logic [OpW-1:0]     in_opcode;
  logic [TimeW-1:0]   in_now_ms;
  logic               in_radio_connected;
  logic               in_worn;
  logic               in_motion_detected;

  logic               out_valid;
  logic               out_stall;
  logic [ModeW-1:0]   out_power_mode;
  logic               out_dim_sensors;
  logic               out_restore_sensors;
  logic               out_radio_stop;
  logic               out_radio_start;
  logic               out_wear_check_request;
  logic               out_light_sleep_request;
  logic               out_deep_sleep_request;

  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [TimeW-1:0]   cfg_data;

  // checker results
  int unsigned mismatches;
  int unsigned pending;
  int unsigned results_seen;
  int unsigned light_entries;
  int unsigned deep_requests;

  // sender bookkeeping
  int unsigned events_sent;
  int unsigned burst_left;
  bit          offer_open;
  logic [TimeW-1:0] t_now;     // running millisecond clock of the stimulus
  logic [TimeW-1:0] span_ms;   // typical step between events in this phase

  // hold-off handshake between the stimulus and the receiver process
  int unsigned holds_asked;
  int unsigned holds_served;

  // 8 time unit clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  wear_aware_power_mode_controller_unit i_dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_opcode               (in_opcode),
    .in_now_ms               (in_now_ms),
    .in_radio_connected      (in_radio_connected),
    .in_worn                 (in_worn),
    .in_motion_detected      (in_motion_detected),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_power_mode          (out_power_mode),
    .out_dim_sensors         (out_dim_sensors),
    .out_restore_sensors     (out_restore_sensors),
    .out_radio_stop          (out_radio_stop),
    .out_radio_start         (out_radio_start),
    .out_wear_check_request  (out_wear_check_request),
    .out_light_sleep_request (out_light_sleep_request),
    .out_deep_sleep_request  (out_deep_sleep_request),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data)
  );

  wapm_mode_checker i_mode_checker (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_opcode               (in_opcode),
    .in_now_ms               (in_now_ms),
    .in_radio_connected      (in_radio_connected),
    .in_worn                 (in_worn),
    .in_motion_detected      (in_motion_detected),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_power_mode          (out_power_mode),
    .out_dim_sensors         (out_dim_sensors),
    .out_restore_sensors     (out_restore_sensors),
    .out_radio_stop          (out_radio_stop),
    .out_radio_start         (out_radio_start),
    .out_wear_check_request  (out_wear_check_request),
    .out_light_sleep_request (out_light_sleep_request),
    .out_deep_sleep_request  (out_deep_sleep_request),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data),
    .mismatch_count          (mismatches),
    .pending_count           (pending),
    .result_count            (results_seen),
    .light_entries           (light_entries),
    .deep_requests           (deep_requests)
  );

  // true with odds of one in one_in
  function automatic bit coin(input int unsigned one_in);
    return $urandom_range(0, one_in - 1) == 0;
  endfunction

  // time step between events: mostly within the phase span, sometimes none,
  // sometimes a jump anywhere on the 32-bit circle (backward or wrapping)
  function automatic logic [TimeW-1:0] step_ms();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return $urandom();
      default: return $urandom_range(0, span_ms);
    endcase
  endfunction

  // Offer one event and hold it until the block takes it. Called at a falling
  // edge, returns at a falling edge. Bursts and gaps are decided here, so the
  // valid line is lowered only here and in settle, and raised at a later edge.
  task automatic post_event(input logic [OpW-1:0] op, input logic [TimeW-1:0] now,
                            input logic link, input logic worn, input logic motion);
    in_valid <= 1'b1;
    in_opcode <= op;
    in_now_ms <= now;
    in_radio_connected <= link;
    in_worn <= worn;
    in_motion_detected <= motion;
    offer_open = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    events_sent++;
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      // now and then a long back-to-back stretch, mostly short bursts
      burst_left = coin(6) ? $urandom_range(30, 80) : $urandom_range(1, 10);
      if (!coin(4)) begin
        in_valid <= 1'b0;
        offer_open = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
  endtask

  // Close the event channel and wait until every result has come back.
  task automatic settle();
    int unsigned guard;
    guard = 0;
    if (offer_open) begin
      in_valid <= 1'b0;
      offer_open = 1'b0;
    end
    while (pending != 0 && guard < DRAIN_GUARD) begin
      @(negedge clk);
      guard++;
    end
    // two-stage pipe: the extra wait covers anything still in flight
    repeat (4) @(negedge clk);
  endtask

  // Write all three timeouts, optionally followed by a write to the unmapped
  // index. Only called with the block idle.
  task automatic program_regs(input logic [TimeW-1:0] grace, input logic [TimeW-1:0] removal,
                              input logic [TimeW-1:0] idle, input bit poke_spare);
    logic [CfgIdxW-1:0] idx [4];
    logic [TimeW-1:0]   val [4];
    int unsigned        n;
    idx[0] = REG_GRACE;   val[0] = grace;
    idx[1] = REG_REMOVAL; val[1] = removal;
    idx[2] = REG_IDLE;    val[2] = idle;
    idx[3] = REG_SPARE;   val[3] = $urandom();
    n = poke_spare ? 4 : 3;
    for (int k = 0; k < int'(n); k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= val[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // One random stretch of events. Most are well-formed usage sequences
  // (removal countdown into sleep, wakes while asleep, unlinked idling),
  // the rest is noise with any opcode, time and flags.
  task automatic random_scenario();
    int unsigned pick;
    int unsigned n;
    logic link;
    pick = $urandom_range(0, 99);
    link = !coin(5);
    if (pick < 10) begin
      post_event(OP_START, t_now, link, 1'b1, coin(2));
    end else if (pick < 50) begin
      // taken off: countdown updates, then the transition check
      n = $urandom_range(1, 5);
      repeat (n) begin
        t_now += step_ms();
        post_event(OP_UPDATE, t_now, link, coin(8), coin(8));
      end
      t_now += $urandom_range(1, span_ms);
      post_event(OP_UPDATE, t_now, link, coin(5), coin(5));
    end else if (pick < 72) begin
      // wakes, which matter mostly in light sleep
      n = $urandom_range(1, 4);
      repeat (n) begin
        t_now += $urandom_range(0, span_ms);
        post_event(coin(3) ? OP_OTHER : OP_TIMER, t_now, coin(2), coin(2), coin(4));
      end
    end else if (pick < 82) begin
      // long unlinked stretch, aims at the idle timeout
      t_now += span_ms * $urandom_range(2, 12);
      post_event(OP_UPDATE, t_now, 1'b0, !coin(4), coin(2));
      if (coin(2)) begin
        t_now += step_ms();
        post_event(OP_UPDATE, t_now, coin(2), coin(2), coin(2));
      end
    end else if (pick < 88) begin
      t_now += step_ms();
      post_event(OP_BUTTON, t_now, coin(2), coin(2), coin(2));
    end else begin
      post_event(OpW'($urandom_range(0, (1 << OpW) - 1)), coin(2) ? $urandom() : t_now,
                 coin(2), coin(2), coin(2));
    end
  endtask

  task automatic run_traffic(input int unsigned count);
    int unsigned goal;
    goal = events_sent + count;
    while (events_sent < goal) random_scenario();
  endtask

  // Receiver: stall patterns in phases of random length, plus the long
  // hold-off whenever the stimulus asks for one.
  initial begin : receiver
    stall_mode_t kind;
    int unsigned phase_len;
    out_stall = 1'b0;
    holds_served = 0;
    forever begin
      if (holds_asked > holds_served) begin
        repeat (HOLD_OFF_CYCLES) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
        holds_served++;
      end
      kind = stall_mode_t'($urandom_range(0, 3));
      phase_len = $urandom_range(5, 60);
      repeat (phase_len) begin
        @(negedge clk);
        case (kind)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= coin(4);
          STALL_HEAVY: out_stall <= !coin(4);
          default:     out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_UPDATE;
    in_now_ms = '0;
    in_radio_connected = 1'b0;
    in_worn = 1'b0;
    in_motion_detected = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_GRACE;
    cfg_data = '0;
    events_sent = 0;
    offer_open = 1'b0;
    holds_asked = 0;
    burst_left = $urandom_range(1, 10);
    t_now = '0;
    span_ms = '0;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed walk on the reset timeouts (grace 10 s, removal 60 s,
    // idle 300 s); every update is linked until the idle check at the end
    post_event(OP_START,  32'd0,      1'b1, 1'b1, 1'b0);
    post_event(OP_UPDATE, 32'd5000,   1'b1, 1'b0, 1'b0); // inside grace: ignored
    post_event(OP_UPDATE, 32'd10000,  1'b1, 1'b0, 1'b0); // off the wrist: countdown
    post_event(OP_UPDATE, 32'd20000,  1'b1, 1'b0, 1'b0); // still counting
    post_event(OP_UPDATE, 32'd70000,  1'b1, 1'b0, 1'b0); // exactly at timeout: transition
    post_event(OP_UPDATE, 32'd70001,  1'b1, 1'b0, 1'b1); // motion in transition: active
    post_event(OP_UPDATE, 32'd70002,  1'b1, 1'b0, 1'b0); // countdown again
    post_event(OP_UPDATE, 32'd70003,  1'b1, 1'b1, 1'b0); // worn during check: active
    post_event(OP_UPDATE, 32'd70004,  1'b1, 1'b0, 1'b0);
    post_event(OP_UPDATE, 32'd130004, 1'b1, 1'b0, 1'b0); // transition
    post_event(OP_UPDATE, 32'd130005, 1'b1, 1'b1, 1'b0); // worn in transition: active
    post_event(OP_UPDATE, 32'd130006, 1'b1, 1'b0, 1'b0);
    post_event(OP_UPDATE, 32'd190006, 1'b1, 1'b0, 1'b0); // transition
    post_event(OP_UPDATE, 32'd190007, 1'b1, 1'b0, 1'b0); // still: light sleep, dim + stop
    post_event(OP_OTHER,  32'd190008, 1'b0, 1'b0, 1'b0); // other wake: back to sleep
    post_event(OP_TIMER,  32'd190009, 1'b0, 1'b0, 1'b0); // timer, no motion: check + sleep
    post_event(OP_UPDATE, 32'd190010, 1'b1, 1'b1, 1'b0); // update in light sleep: active
    post_event(OP_UPDATE, 32'd190011, 1'b1, 1'b0, 1'b0);
    post_event(OP_UPDATE, 32'd250011, 1'b1, 1'b0, 1'b0);
    post_event(OP_UPDATE, 32'd250012, 1'b1, 1'b0, 1'b0); // light sleep again
    post_event(OP_TIMER,  32'd250013, 1'b0, 1'b0, 1'b1); // timer with motion: wakes
    post_event(OP_TIMER,  32'd250014, 1'b0, 1'b0, 1'b1); // wakes outside sleep: ignored
    post_event(OP_OTHER,  32'd250015, 1'b0, 1'b1, 1'b1);
    // undefined opcodes: ignored
    for (int k = int'(OP_OTHER) + 1; k < (1 << OpW); k++)
      post_event(OpW'(k), $urandom(), 1'b1, 1'b1, 1'b1);
    post_event(OP_UPDATE, 32'd550014, 1'b0, 1'b1, 1'b0); // unlinked past idle: deep sleep
    post_event(OP_UPDATE, 32'd550015, 1'b0, 1'b1, 1'b0); // deep holds, request again
    post_event(OP_BUTTON, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1); // button out of deep sleep
    settle();

    // ---- short timeouts: full countdown, sleep and idle paths are reachable
    program_regs(32'd20, 32'd200, 32'd1500, 1'b0);
    t_now = '0;
    span_ms = 32'd80;
    run_traffic(250);
    settle();

    // ---- all zero: no grace, instant removal, any idle time counts
    program_regs('0, '0, '0, 1'b1);
    span_ms = 32'd8;
    run_traffic(150);
    settle();

    // ---- all ones: grace almost never ends, no idle ever
    program_regs('1, '1, '1, 1'b0);
    span_ms = '1;
    run_traffic(100);
    settle();

    // ---- random register values, random times
    program_regs($urandom(), $urandom(), $urandom(), 1'b1);
    span_ms = $urandom();
    run_traffic(100);
    settle();

    // ---- small timeouts again, with a long receiver hold-off early on
    program_regs(32'd5, 32'd50, 32'd400, 1'b0);
    span_ms = 32'd20;
    run_traffic(50);
    holds_asked++;
    run_traffic(350);
    settle();

    if (pending != 0) $display("%0d expected results never arrived", pending);
    $display("Sent %0d events over six timeout settings, %0d long receiver hold-off(s).",
             events_sent, holds_served);
    $display("Checked %0d results: %0d light sleep entries, %0d deep sleep requests.",
             results_seen, light_entries, deep_requests);
    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog, far above the slowest correct run
  initial begin : watchdog
    #2000000;
    $display("Run timed out with %0d results outstanding", pending);
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> filelist.f
src/wapm_pkg.sv
src/wapm_cfg_regs.sv
src/wapm_mode_core.sv
src/wear_aware_power_mode_controller_unit.sv
tb/wapm_mode_checker.sv
tb/wear_aware_power_mode_controller_unit_test.sv
